>>> rtl/mac_pkg.sv
// ----------------------------------------------------------------------------
// mac_pkg
// Shared types, codes and reset values for the motion alarm controller.
// ----------------------------------------------------------------------------
package mac_pkg;

	// Default build parameters
	localparam int SAMPLE_BITS_DEF = 12;
	localparam int AXES_DEF        = 3;
	localparam int AXES_MAX        = 3;

	// Field and register widths
	localparam int MODE_W    = 2;
	localparam int PHASE_W   = 3;
	localparam int LIMIT_W   = 12;
	localparam int TICK_W    = 16;
	localparam int COUNT8_W  = 8;
	localparam int STEP_W    = 9;
	localparam int PERIOD_W  = 16;
	localparam int COMPARE_W = 15;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 16;

	// Register reset values
	localparam logic [LIMIT_W-1:0]  LIMIT_RST     = 12'd200;
	localparam logic [TICK_W-1:0]   HALF_RST      = 16'd500;
	localparam logic [COUNT8_W-1:0] CYCLES_RST    = 8'd60;
	localparam logic [TICK_W-1:0]   HOLDOFF_RST   = 16'd2000;
	localparam logic [COUNT8_W-1:0] BLINK_RST     = 8'd6;
	localparam logic [PERIOD_W-1:0] LOW_TONE_RST  = 16'd3494;
	localparam logic [PERIOD_W-1:0] HIGH_TONE_RST = 16'd1612;

	typedef enum logic [PHASE_W-1:0] {
		PH_OFF    = 3'd0,
		PH_ARMING = 3'd1,
		PH_ARMED  = 3'd2,
		PH_SIREN  = 3'd3,
		PH_HOLD   = 3'd4
	} phase_t;

	typedef enum logic [MODE_W-1:0] {
		MODE_TICK   = 2'd0,
		MODE_PRESS  = 2'd1,
		MODE_SAMPLE = 2'd2
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LIMIT     = 3'd0,
		CFG_HALF      = 3'd1,
		CFG_CYCLES    = 3'd2,
		CFG_HOLDOFF   = 3'd3,
		CFG_BLINK     = 3'd4,
		CFG_LOW_TONE  = 3'd5,
		CFG_HIGH_TONE = 3'd6
	} cfg_idx_t;

	typedef struct packed {
		logic [PHASE_W-1:0]   phase;
		logic                 green_led;
		logic                 red_led;
		logic [PERIOD_W-1:0]  buzzer_period;
		logic [COMPARE_W-1:0] buzzer_compare;
		logic                 motion_seen;
	} rsp_t;

	// Status from the motion detector to the controller
	typedef struct packed {
		logic all_zero;
		logic motion;
	} det_t;

endpackage

>>> rtl/mac_ifs.sv
// ----------------------------------------------------------------------------
// mac_ifs
// Valid/ready channels for command transactions and result transactions.
// ----------------------------------------------------------------------------
interface mac_cmd_if #(
	parameter int SAMPLE_BITS = mac_pkg::SAMPLE_BITS_DEF
);
	logic                        valid;
	logic                        ready;
	logic [mac_pkg::MODE_W-1:0]  mode;
	logic [SAMPLE_BITS-1:0]      axis_x;
	logic [SAMPLE_BITS-1:0]      axis_y;
	logic [SAMPLE_BITS-1:0]      axis_z;

	modport source (output valid, output mode, output axis_x, output axis_y,
		output axis_z, input ready);
	modport sink (input valid, input mode, input axis_x, input axis_y,
		input axis_z, output ready);
endinterface

interface mac_rsp_if;
	logic                           valid;
	logic                           ready;
	logic [mac_pkg::PHASE_W-1:0]    phase;
	logic                           green_led;
	logic                           red_led;
	logic [mac_pkg::PERIOD_W-1:0]   buzzer_period;
	logic [mac_pkg::COMPARE_W-1:0]  buzzer_compare;
	logic                           motion_seen;

	modport source (output valid, output phase, output green_led, output red_led,
		output buzzer_period, output buzzer_compare, output motion_seen,
		input ready);
	modport sink (input valid, input phase, input green_led, input red_led,
		input buzzer_period, input buzzer_compare, input motion_seen,
		output ready);
endinterface

>>> rtl/mac_motion_det.sv
// ----------------------------------------------------------------------------
// mac_motion_det
// Per-axis absolute deviation check against the stored reference.
// ----------------------------------------------------------------------------
module mac_motion_det #(
	parameter int SAMPLE_BITS = mac_pkg::SAMPLE_BITS_DEF,
	parameter int AXES_USED   = mac_pkg::AXES_DEF
) (
	input  logic [AXES_USED-1:0][SAMPLE_BITS-1:0] sample,
	input  logic [AXES_USED-1:0][SAMPLE_BITS-1:0] refs,
	input  logic [mac_pkg::LIMIT_W-1:0]           limit,
	output mac_pkg::det_t                         status
);
	import mac_pkg::*;

	localparam int CMP_W = (SAMPLE_BITS > LIMIT_W) ? SAMPLE_BITS : LIMIT_W;

	logic [AXES_USED-1:0] over;
	logic [AXES_USED-1:0] nonzero;

	// Empty reference triple means the next sample becomes the reference
	always_comb begin
		logic [SAMPLE_BITS-1:0] mag;
		for (int i = 0; i < AXES_USED; i++) begin
			if (sample[i] >= refs[i]) begin
				mag = sample[i] - refs[i];
			end else begin
				mag = refs[i] - sample[i];
			end
			over[i]    = CMP_W'(mag) > CMP_W'(limit);
			nonzero[i] = |refs[i];
		end
	end

	assign status.all_zero = ~|nonzero;
	assign status.motion   = |over;

endmodule

>>> rtl/motion_alarm_controller_core.sv
// ----------------------------------------------------------------------------
// motion_alarm_controller_core
// Motion alarm: arming blink, reference capture, siren tones and holdoff.
// ----------------------------------------------------------------------------
// A result is registered from its command transaction into the output or skid entry.
// Throughput: one command transaction per cycle while the skid is empty; the whole
//   state update is a single pass of compare and counter logic into the state registers.
// A two-entry result buffer (output register plus skid) keeps commands flowing
//   while a result waits; command ready drops only when both entries are full.
// Reset (arst_n low): disarmed, references zero, counters zero, registers at
//   their default values, result buffer empty.
module motion_alarm_controller_core #(
	parameter int SAMPLE_BITS = mac_pkg::SAMPLE_BITS_DEF,
	parameter int AXES        = mac_pkg::AXES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	mac_cmd_if.sink                       cmd,
	mac_rsp_if.source                     result,
	input  logic                          cfg_we,
	input  logic [mac_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mac_pkg::CFG_DAT_W-1:0] cfg_data
);
	import mac_pkg::*;

	// Only the first three axes exist on the command channel
	localparam int AXES_USED = (AXES < AXES_MAX) ? AXES : AXES_MAX;

	// ---------------------------------------------------------------- config
	logic [LIMIT_W-1:0]  limit_q;
	logic [TICK_W-1:0]   half_q;
	logic [COUNT8_W-1:0] cycles_q;
	logic [TICK_W-1:0]   holdoff_q;
	logic [COUNT8_W-1:0] blink_q;
	logic [PERIOD_W-1:0] low_tone_q;
	logic [PERIOD_W-1:0] high_tone_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q     <= LIMIT_RST;
			half_q      <= HALF_RST;
			cycles_q    <= CYCLES_RST;
			holdoff_q   <= HOLDOFF_RST;
			blink_q     <= BLINK_RST;
			low_tone_q  <= LOW_TONE_RST;
			high_tone_q <= HIGH_TONE_RST;
		end else if (cfg_we) begin
			// Indexes beyond the register list are dropped
			unique case (cfg_idx_t'(cfg_index))
				CFG_LIMIT:     limit_q     <= cfg_data[LIMIT_W-1:0];
				CFG_HALF:      half_q      <= cfg_data[TICK_W-1:0];
				CFG_CYCLES:    cycles_q    <= cfg_data[COUNT8_W-1:0];
				CFG_HOLDOFF:   holdoff_q   <= cfg_data[TICK_W-1:0];
				CFG_BLINK:     blink_q     <= cfg_data[COUNT8_W-1:0];
				CFG_LOW_TONE:  low_tone_q  <= cfg_data[PERIOD_W-1:0];
				CFG_HIGH_TONE: high_tone_q <= cfg_data[PERIOD_W-1:0];
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------- state
	phase_t                               phase_q, phase_d;
	logic [AXES_USED-1:0][SAMPLE_BITS-1:0] ref_q, ref_d;
	logic [TICK_W-1:0]                    tick_q, tick_d;
	logic [STEP_W-1:0]                    step_q, step_d;
	logic                                 green_q, green_d;
	logic                                 high_q, high_d;
	logic                                 seen_d;

	logic                                 accept;

	// Sample lanes: pick the used axes off the channel
	logic [AXES_MAX-1:0][SAMPLE_BITS-1:0] all_axes;
	logic [AXES_USED-1:0][SAMPLE_BITS-1:0] sample;
	det_t                                 det;

	assign all_axes = {cmd.axis_z, cmd.axis_y, cmd.axis_x};

	always_comb begin
		for (int i = 0; i < AXES_USED; i++) begin
			sample[i] = all_axes[i];
		end
	end

	// While the references are empty, compare against the sample itself
	logic [AXES_USED-1:0][SAMPLE_BITS-1:0] cmp_ref;
	assign cmp_ref = det.all_zero ? sample : ref_q;

	// Alarm decision against the effective reference
	det_t det_eff;

	mac_motion_det #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.AXES_USED   (AXES_USED)
	) u_det_eff (
		.sample (sample),
		.refs   (cmp_ref),
		.limit  (limit_q),
		.status (det_eff)
	);

	// Reference emptiness depends on the stored triple only
	always_comb begin
		det.all_zero = 1'b1;
		det.motion   = 1'b0;
		for (int i = 0; i < AXES_USED; i++) begin
			if (|ref_q[i]) begin
				det.all_zero = 1'b0;
			end
		end
	end

	// Half-period and holdoff timers share one tick counter
	logic [TICK_W-1:0] tick_inc;
	logic [STEP_W-1:0] step_inc;
	logic              half_done;
	logic              hold_done;

	assign tick_inc  = tick_q + 1'b1;
	assign step_inc  = step_q + 1'b1;
	assign half_done = (tick_inc >= half_q) || (tick_inc == '0);
	assign hold_done = (tick_inc >= holdoff_q) || (tick_inc == '0);

	always_comb begin
		phase_d = phase_q;
		ref_d   = ref_q;
		tick_d  = tick_q;
		step_d  = step_q;
		green_d = green_q;
		high_d  = high_q;
		seen_d  = 1'b0;

		unique case (mode_t'(cmd.mode))
			MODE_TICK: begin
				unique case (phase_q)
					PH_ARMING: begin
						if (half_done) begin
							tick_d = '0;
							if (step_q >= STEP_W'(blink_q)) begin
								// Blink sequence done: arm with green on
								phase_d = PH_ARMED;
								green_d = 1'b1;
								step_d  = '0;
							end else begin
								green_d = ~green_q;
								step_d  = step_inc;
							end
						end else begin
							tick_d = tick_inc;
						end
					end
					PH_SIREN: begin
						if (half_done) begin
							tick_d = '0;
							if (!high_q) begin
								high_d = 1'b1;
							end else begin
								// End of a low/high pair
								high_d = 1'b0;
								if (step_inc >= STEP_W'(cycles_q)) begin
									step_d  = '0;
									phase_d = (holdoff_q == '0) ? PH_ARMED : PH_HOLD;
								end else begin
									step_d = step_inc;
								end
							end
						end else begin
							tick_d = tick_inc;
						end
					end
					PH_HOLD: begin
						if (hold_done) begin
							tick_d  = '0;
							phase_d = PH_ARMED;
						end else begin
							tick_d = tick_inc;
						end
					end
					default: ;
				endcase
			end
			MODE_PRESS: begin
				tick_d = '0;
				if (phase_q == PH_OFF) begin
					if (blink_q == '0) begin
						phase_d = PH_ARMED;
						green_d = 1'b1;
						step_d  = '0;
					end else begin
						phase_d = PH_ARMING;
						green_d = ~green_q;
						step_d  = STEP_W'(1);
					end
				end else begin
					// Silencing the siren also forgets the references
					if (phase_q == PH_SIREN) begin
						ref_d = '0;
					end
					phase_d = PH_OFF;
					green_d = 1'b0;
					high_d  = 1'b0;
					step_d  = '0;
				end
			end
			MODE_SAMPLE: begin
				if (phase_q == PH_ARMED) begin
					if (det.all_zero) begin
						ref_d = sample;
					end
					if (det_eff.motion) begin
						phase_d = PH_SIREN;
						high_d  = 1'b0;
						tick_d  = '0;
						step_d  = '0;
						seen_d  = 1'b1;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_OFF;
			ref_q   <= '0;
			tick_q  <= '0;
			step_q  <= '0;
			green_q <= 1'b0;
			high_q  <= 1'b0;
		end else if (accept) begin
			phase_q <= phase_d;
			ref_q   <= ref_d;
			tick_q  <= tick_d;
			step_q  <= step_d;
			green_q <= green_d;
			high_q  <= high_d;
		end
	end

	// ---------------------------------------------------------------- result
	rsp_t                rsp_d;
	logic [PERIOD_W-1:0] period_d;
	logic                siren_d;

	assign siren_d  = (phase_d == PH_SIREN);
	assign period_d = siren_d ? (high_d ? high_tone_q : low_tone_q) : '0;

	always_comb begin
		rsp_d.phase          = phase_d;
		rsp_d.green_led      = green_d;
		rsp_d.red_led        = siren_d && !high_d;
		rsp_d.buzzer_period  = period_d;
		rsp_d.buzzer_compare = period_d[PERIOD_W-1:1];
		rsp_d.motion_seen    = seen_d;
	end

	// Output register plus skid entry
	logic out_valid_q;
	logic skid_valid_q;
	rsp_t out_q;
	rsp_t skid_q;
	logic pop;

	assign cmd.ready = !skid_valid_q;
	assign accept    = cmd.valid && cmd.ready;
	assign pop       = out_valid_q && result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			// Drain the skid entry first; no transaction is taken meanwhile
			if (pop) begin
				skid_valid_q <= 1'b0;
			end
		end else if (accept) begin
			if (out_valid_q && !pop) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				out_q <= skid_q;
			end
		end else if (accept) begin
			if (out_valid_q && !pop) begin
				skid_q <= rsp_d;
			end else begin
				out_q <= rsp_d;
			end
		end
	end

	assign result.valid          = out_valid_q;
	assign result.phase          = out_q.phase;
	assign result.green_led      = out_q.green_led;
	assign result.red_led        = out_q.red_led;
	assign result.buzzer_period  = out_q.buzzer_period;
	assign result.buzzer_compare = out_q.buzzer_compare;
	assign result.motion_seen    = out_q.motion_seen;

endmodule

>>> rtl/mac_checker.sv
// ----------------------------------------------------------------------------
// mac_checker
// Port-level checks on result transactions of the motion alarm controller.
// ----------------------------------------------------------------------------
module mac_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           rsp_valid,
	input logic                           rsp_ready,
	input logic [mac_pkg::PHASE_W-1:0]    rsp_phase,
	input logic                           rsp_red_led,
	input logic [mac_pkg::PERIOD_W-1:0]   rsp_period,
	input logic [mac_pkg::COMPARE_W-1:0]  rsp_compare,
	input logic                           rsp_motion
);
	import mac_pkg::*;

	// Hold a stalled result
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_phase)
			&& $stable(rsp_period) && $stable(rsp_motion))
		else $error("result changed while stalled");

	a_compare_half: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_compare == rsp_period[PERIOD_W-1:1])
		else $error("buzzer compare is not half the period");

	a_quiet_off_siren: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_phase != PH_SIREN |-> rsp_period == '0 && !rsp_red_led)
		else $error("buzzer or red indicator active outside the siren");

	a_motion_starts_siren: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_motion |-> rsp_phase == PH_SIREN)
		else $error("motion reported without entering the siren");

endmodule

bind motion_alarm_controller_core mac_checker u_mac_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.rsp_valid   (result.valid),
	.rsp_ready   (result.ready),
	.rsp_phase   (result.phase),
	.rsp_red_led (result.red_led),
	.rsp_period  (result.buzzer_period),
	.rsp_compare (result.buzzer_compare),
	.rsp_motion  (result.motion_seen)
);

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the motion alarm core. Commands (ticks, presses,
// samples) are pushed through the valid/ready channel with random gaps while
// the result side stalls at random. A scoreboard carries its own model of
// the alarm state machine and checks every result transaction in order.
// ----------------------------------------------------------------------------
module tb;
	import mac_pkg::*;

	localparam int SAMPLE_MAX      = (1 << SAMPLE_BITS_DEF) - 1;
	localparam int RANDOM_PHASES   = 8;
	localparam int ITEMS_PER_PHASE = 115;
	localparam int NUM_REGS        = 7;
	// Mode code that the block must ignore
	localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DAT_W-1:0] cfg_data;
	logic [CFG_DAT_W-1:0] cfg_vals [NUM_REGS];
	bit steady = 1'b0;

	mac_cmd_if cmd_ch ();
	mac_rsp_if rsp_ch ();

	motion_alarm_controller_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_ch),
		.result    (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Scoreboard: shadow copy of the alarm state and a queue of the results
	// that the accepted commands must produce, oldest first.
	class alarm_scoreboard;
		logic [LIMIT_W-1:0]         limit;
		logic [TICK_W-1:0]          half_ticks;
		logic [COUNT8_W-1:0]        pairs;
		logic [TICK_W-1:0]          holdoff;
		logic [COUNT8_W-1:0]        blinks;
		logic [PERIOD_W-1:0]        low_tone;
		logic [PERIOD_W-1:0]        high_tone;
		phase_t                     ph;
		logic [SAMPLE_BITS_DEF-1:0] refs [AXES_DEF];
		logic [TICK_W-1:0]          ticks;
		logic [STEP_W-1:0]          steps;
		logic                       green;
		logic                       high_now;
		rsp_t                       expected_q [$];
		int                         errors;

		function new();
			limit      = LIMIT_RST;
			half_ticks = HALF_RST;
			pairs      = CYCLES_RST;
			holdoff    = HOLDOFF_RST;
			blinks     = BLINK_RST;
			low_tone   = LOW_TONE_RST;
			high_tone  = HIGH_TONE_RST;
			ph         = PH_OFF;
			foreach (refs[i])
				refs[i] = '0;
			ticks    = '0;
			steps    = '0;
			green    = 1'b0;
			high_now = 1'b0;
			errors   = 0;
		endfunction

		function void set_reg(cfg_idx_t idx, logic [CFG_DAT_W-1:0] val);
			case (idx)
				CFG_LIMIT:     limit = val[LIMIT_W-1:0];
				CFG_HALF:      half_ticks = val[TICK_W-1:0];
				CFG_CYCLES:    pairs = val[COUNT8_W-1:0];
				CFG_HOLDOFF:   holdoff = val[TICK_W-1:0];
				CFG_BLINK:     blinks = val[COUNT8_W-1:0];
				CFG_LOW_TONE:  low_tone = val[PERIOD_W-1:0];
				CFG_HIGH_TONE: high_tone = val[PERIOD_W-1:0];
				default: ;
			endcase
		endfunction

		// A zero half period elapses on every tick, as does a wrapped counter
		function bit half_done();
			ticks = ticks + 1'b1;
			if (ticks >= half_ticks || ticks == '0) begin
				ticks = '0;
				return 1'b1;
			end
			return 1'b0;
		endfunction

		function void advance_tick();
			case (ph)
				PH_ARMING: begin
					if (half_done()) begin
						if (steps >= blinks) begin
							ph    = PH_ARMED;
							green = 1'b1;
							steps = '0;
						end else begin
							green = ~green;
							steps = steps + 1'b1;
						end
					end
				end
				PH_SIREN: begin
					if (half_done()) begin
						if (!high_now) begin
							high_now = 1'b1;
						end else begin
							high_now = 1'b0;
							steps    = steps + 1'b1;
							if (steps >= pairs) begin
								steps = '0;
								ticks = '0;
								ph    = (holdoff == '0) ? PH_ARMED : PH_HOLD;
							end
						end
					end
				end
				PH_HOLD: begin
					ticks = ticks + 1'b1;
					if (ticks >= holdoff || ticks == '0) begin
						ticks = '0;
						ph    = PH_ARMED;
					end
				end
				default: ;
			endcase
		endfunction

		function void button_press();
			if (ph == PH_OFF) begin
				ticks = '0;
				if (blinks == '0) begin
					ph    = PH_ARMED;
					green = 1'b1;
					steps = '0;
				end else begin
					ph    = PH_ARMING;
					green = ~green;
					steps = STEP_W'(1);
				end
			end else begin
				// Only a press during the siren forgets the references
				if (ph == PH_SIREN)
					foreach (refs[i])
						refs[i] = '0;
				ph       = PH_OFF;
				green    = 1'b0;
				high_now = 1'b0;
				ticks    = '0;
				steps    = '0;
			end
		endfunction

		function bit take_sample(logic [SAMPLE_BITS_DEF-1:0] s [AXES_DEF]);
			bit all_zero;
			int d;
			if (ph != PH_ARMED)
				return 1'b0;
			all_zero = 1'b1;
			foreach (refs[i])
				if (refs[i] != '0)
					all_zero = 1'b0;
			if (all_zero)
				foreach (refs[i])
					refs[i] = s[i];
			foreach (refs[i]) begin
				d = int'(s[i]) - int'(refs[i]);
				if (d < 0)
					d = -d;
				if (d > int'(limit)) begin
					ph       = PH_SIREN;
					high_now = 1'b0;
					ticks    = '0;
					steps    = '0;
					return 1'b1;
				end
			end
			return 1'b0;
		endfunction

		function void note_command(logic [MODE_W-1:0] m, logic [SAMPLE_BITS_DEF-1:0] s [AXES_DEF]);
			rsp_t want;
			logic seen;
			logic [PERIOD_W-1:0] period;
			seen = 1'b0;
			case (m)
				MODE_TICK:   advance_tick();
				MODE_PRESS:  button_press();
				MODE_SAMPLE: seen = take_sample(s);
				default: ;
			endcase
			period = '0;
			want.red_led = 1'b0;
			if (ph == PH_SIREN) begin
				period = high_now ? high_tone : low_tone;
				want.red_led = ~high_now;
			end
			want.phase          = ph;
			want.green_led      = green;
			want.buzzer_period  = period;
			want.buzzer_compare = period[PERIOD_W-1:1];
			want.motion_seen    = seen;
			expected_q.push_back(want);
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				$display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
				errors++;
			end
		endfunction

		function void check_result(rsp_t got);
			rsp_t want;
			if (expected_q.size() == 0) begin
				$display("%0t ns: unexpected result %h", $time, got);
				errors++;
				return;
			end
			want = expected_q.pop_front();
			compare_field("phase", 32'(want.phase), 32'(got.phase));
			compare_field("green_led", 32'(want.green_led), 32'(got.green_led));
			compare_field("red_led", 32'(want.red_led), 32'(got.red_led));
			compare_field("buzzer_period", 32'(want.buzzer_period),
				32'(got.buzzer_period));
			compare_field("buzzer_compare", 32'(want.buzzer_compare),
				32'(got.buzzer_compare));
			compare_field("motion_seen", 32'(want.motion_seen), 32'(got.motion_seen));
		endfunction
	endclass

	alarm_scoreboard sb;

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Idle length: mostly none or short, now and then long; none in a steady phase
	function automatic int pick_gap();
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Offer one command transaction after a random gap; hold it until taken,
	// then hand it to the scoreboard. Valid is left high for a back-to-back
	// follower so that it is never lowered and raised in the same step.
	task automatic send_cmd(logic [MODE_W-1:0] m, logic [SAMPLE_BITS_DEF-1:0] x,
		logic [SAMPLE_BITS_DEF-1:0] y, logic [SAMPLE_BITS_DEF-1:0] z);
		int gap;
		logic [SAMPLE_BITS_DEF-1:0] s [AXES_DEF];
		gap = pick_gap();
		repeat (gap) begin
			cmd_ch.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_ch.valid  <= 1'b1;
		cmd_ch.mode   <= m;
		cmd_ch.axis_x <= x;
		cmd_ch.axis_y <= y;
		cmd_ch.axis_z <= z;
		@(posedge clk);
		while (!cmd_ch.ready)
			@(posedge clk);
		s[0] = x;
		s[1] = y;
		s[2] = z;
		sb.note_command(m, s);
	endtask

	// Drop valid and wait until every expected result has been collected
	task automatic settle();
		cmd_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	// Write all registers from cfg_vals, one per clock, holding the enable
	// across the burst
	task automatic write_config();
		cfg_idx_t idx;
		idx = idx.first();
		do begin
			cfg_we    <= 1'b1;
			cfg_index <= idx;
			cfg_data  <= cfg_vals[int'(idx)];
			@(posedge clk);
			sb.set_reg(idx, cfg_vals[int'(idx)]);
			idx = idx.next();
		end while (idx != idx.first());
		cfg_we <= 1'b0;
	endtask

	// Register sets for the random phases: all maxima, all zeros, then small
	// timing values that let arming, siren and holdoff cycle within a phase
	task automatic pick_profile(int k);
		if (k == 0) begin
			foreach (cfg_vals[i])
				cfg_vals[i] = '1;
		end else if (k == 1) begin
			foreach (cfg_vals[i])
				cfg_vals[i] = '0;
		end else begin
			case ($urandom_range(0, 2))
				0: cfg_vals[CFG_LIMIT] = CFG_DAT_W'($urandom_range(0, 64));
				1: cfg_vals[CFG_LIMIT] = CFG_DAT_W'($urandom_range(0, 400));
				default: cfg_vals[CFG_LIMIT] = CFG_DAT_W'($urandom_range(0, SAMPLE_MAX));
			endcase
			cfg_vals[CFG_HALF]      = CFG_DAT_W'($urandom_range(0, 4));
			cfg_vals[CFG_CYCLES]    = CFG_DAT_W'($urandom_range(0, 4));
			cfg_vals[CFG_HOLDOFF]   = CFG_DAT_W'($urandom_range(0, 6));
			cfg_vals[CFG_BLINK]     = CFG_DAT_W'($urandom_range(0, 5));
			cfg_vals[CFG_LOW_TONE]  = CFG_DAT_W'($urandom);
			cfg_vals[CFG_HIGH_TONE] = CFG_DAT_W'($urandom);
		end
	endtask

	// Sample value around a reference: exactly on the limit, just past it, or
	// anywhere within it, on either side
	function automatic logic [SAMPLE_BITS_DEF-1:0] near_ref(logic [SAMPLE_BITS_DEF-1:0] base,
		logic [LIMIT_W-1:0] lim);
		int off;
		int v;
		case ($urandom_range(0, 3))
			0: off = int'(lim);
			1: off = int'(lim) + 1;
			default: off = $urandom_range(0, lim);
		endcase
		v = $urandom_range(0, 1) ? int'(base) + off : int'(base) - off;
		if (v < 0)
			v = 0;
		if (v > SAMPLE_MAX)
			v = SAMPLE_MAX;
		return v[SAMPLE_BITS_DEF-1:0];
	endfunction

	// Mostly ticks and samples near the stored references, some presses and
	// a few spare-mode transactions; non-sample items carry random axes
	task automatic run_random(int count);
		int r;
		logic [SAMPLE_BITS_DEF-1:0] ax [AXES_DEF];
		repeat (count) begin
			r = $urandom_range(0, 99);
			foreach (ax[i])
				ax[i] = SAMPLE_BITS_DEF'($urandom_range(0, SAMPLE_MAX));
			if (r < 52) begin
				send_cmd(MODE_TICK, ax[0], ax[1], ax[2]);
			end else if (r < 60) begin
				send_cmd(MODE_PRESS, ax[0], ax[1], ax[2]);
			end else if (r < 62) begin
				send_cmd(MODE_SPARE, ax[0], ax[1], ax[2]);
			end else begin
				if ($urandom_range(0, 3) != 0)
					foreach (ax[i])
						ax[i] = near_ref(sb.refs[i], sb.limit);
				send_cmd(MODE_SAMPLE, ax[0], ax[1], ax[2]);
			end
		end
	endtask

	// Result side: stall for a random gap, then accept for a random run
	initial begin
		int g;
		rsp_ch.ready <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			g = pick_gap();
			if (g != 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (g) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	end

	// Check each result transaction against the oldest expectation
	always @(posedge clk) begin
		rsp_t got;
		got.phase          = rsp_ch.phase;
		got.green_led      = rsp_ch.green_led;
		got.red_led        = rsp_ch.red_led;
		got.buzzer_period  = rsp_ch.buzzer_period;
		got.buzzer_compare = rsp_ch.buzzer_compare;
		got.motion_seen    = rsp_ch.motion_seen;
		if (arst_n && rsp_ch.valid && rsp_ch.ready)
			sb.check_result(got);
	end

	// Stimulus
	initial begin
		sb = new();
		cmd_ch.valid  <= 1'b0;
		cmd_ch.mode   <= MODE_TICK;
		cmd_ch.axis_x <= '0;
		cmd_ch.axis_y <= '0;
		cmd_ch.axis_z <= '0;
		cfg_we        <= 1'b0;
		cfg_index     <= CFG_LIMIT;
		cfg_data      <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Default registers: ignored samples and spare mode, then a press
		// during arming that only disarms
		send_cmd(MODE_TICK, 12'd0, 12'd0, 12'd0);
		send_cmd(MODE_SAMPLE, 12'hFFF, 12'h000, 12'hFFF);
		send_cmd(MODE_SPARE, 12'hAAA, 12'h555, 12'hFFF);
		send_cmd(MODE_PRESS, 12'h000, 12'h000, 12'h000);
		send_cmd(MODE_TICK, 12'h123, 12'h456, 12'h789);
		send_cmd(MODE_PRESS, 12'h000, 12'h000, 12'h000);
		settle();

		// Fast timing so that one pass reaches every phase
		cfg_vals[CFG_LIMIT]     = 16'd100;
		cfg_vals[CFG_HALF]      = 16'd1;
		cfg_vals[CFG_CYCLES]    = 16'd2;
		cfg_vals[CFG_HOLDOFF]   = 16'd3;
		cfg_vals[CFG_BLINK]     = 16'd2;
		cfg_vals[CFG_LOW_TONE]  = 16'hFFFF;
		cfg_vals[CFG_HIGH_TONE] = 16'd1;
		write_config();

		// Arm with two blink toggles
		send_cmd(MODE_PRESS, 12'h000, 12'h000, 12'h000);
		send_cmd(MODE_TICK, 12'h000, 12'h000, 12'h000);
		send_cmd(MODE_TICK, 12'h000, 12'h000, 12'h000);
		// A zero sample leaves the references zero, so the next one is captured
		send_cmd(MODE_SAMPLE, 12'h000, 12'h000, 12'h000);
		send_cmd(MODE_SAMPLE, 12'hFFF, 12'hFFF, 12'hFFF);
		// On the limit: quiet; one past it on the second axis: siren
		send_cmd(MODE_SAMPLE, 12'd3995, 12'hFFF, 12'hFFF);
		send_cmd(MODE_SAMPLE, 12'hFFF, 12'd3994, 12'hFFF);
		// Two tone pairs, then holdoff, with a sample ignored in each
		send_cmd(MODE_TICK, 12'h000, 12'h000, 12'h000);
		send_cmd(MODE_TICK, 12'h000, 12'h000, 12'h000);
		send_cmd(MODE_SAMPLE, 12'h000, 12'h000, 12'h000);
		send_cmd(MODE_TICK, 12'h000, 12'h000, 12'h000);
		send_cmd(MODE_TICK, 12'h000, 12'h000, 12'h000);
		send_cmd(MODE_SAMPLE, 12'h000, 12'h000, 12'h000);
		repeat (3) send_cmd(MODE_TICK, 12'h000, 12'h000, 12'h000);
		// Re-armed: third axis trips, a press in the siren clears references
		send_cmd(MODE_SAMPLE, 12'hFFF, 12'hFFF, 12'd3000);
		send_cmd(MODE_PRESS, 12'h000, 12'h000, 12'h000);
		send_cmd(MODE_PRESS, 12'h000, 12'h000, 12'h000);
		send_cmd(MODE_TICK, 12'h000, 12'h000, 12'h000);
		send_cmd(MODE_TICK, 12'h000, 12'h000, 12'h000);
		send_cmd(MODE_PRESS, 12'h000, 12'h000, 12'h000);
		settle();

		for (int k = 0; k < RANDOM_PHASES; k++) begin
			pick_profile(k);
			write_config();
			steady = ($urandom_range(0, 3) == 0);
			run_random(ITEMS_PER_PHASE);
			settle();
		end

		repeat (3) @(posedge clk);
		if (sb.errors == 0 && sb.expected_q.size() == 0)
			$display("[motion_alarm_controller_core] OK");
		else
			$display("[motion_alarm_controller_core] ERROR");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run
	initial begin
		#5_000_000;
		$display("[motion_alarm_controller_core] ERROR");
		$finish;
	end

endmodule

>>> filelist.f
rtl/mac_pkg.sv
rtl/mac_ifs.sv
rtl/mac_motion_det.sv
rtl/motion_alarm_controller_core.sv
rtl/mac_checker.sv
tb/tb.sv
